// ===== rtl/core/ssp_pkg.sv =====
// Shared types, constants and the degree-to-width conversion for the servo pulse generator.
package ssp_pkg;

  // Channel count and derived index width
  localparam int CHANNELS = 6;
  localparam int IDX_W    = $clog2(CHANNELS + 1);

  // Field widths fixed by the interface
  localparam int CHAN_W  = 3;
  localparam int DEG_W   = 8;
  localparam int LINES_W = 6;
  localparam int WIDTH_W = 12;
  localparam int TICK_W  = 16;

  // Timing constants
  localparam logic [TICK_W-1:0]  FRAME_DEFAULT = 16'd20000;
  localparam logic [WIDTH_W-1:0] WIDTH_BASE    = 12'd500;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET   = 12'd500;

  // Reciprocal of nine: exact for products below 2^15 with an 18-bit shift
  localparam int          RECIP_SHIFT = 18;
  localparam logic [14:0] RECIP_NINE  = 15'd29128;
  localparam logic [6:0]  DEG_SCALE   = 7'd100;

  // Input item
  typedef struct packed {
    logic              mode;
    logic [CHAN_W-1:0] channel;
    logic [DEG_W-1:0]  degree;
    logic              enable;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [LINES_W-1:0] servo_lines;
    logic               frame_start;
  } out_item_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic               slot_start;
    logic               wr_valid;
    logic [CHAN_W-1:0]  wr_channel;
    logic [WIDTH_W-1:0] wr_width;
    logic               wr_enable;
  } cell_ctrl_t;

  // Data handed from one cell to its neighbor
  typedef struct packed {
    logic               tok;
    logic [WIDTH_W-1:0] width;
  } cell_link_t;

  // Pulse width in microseconds: 100 * degree / 9 + 500
  function automatic logic [WIDTH_W-1:0] deg_to_width(input logic [DEG_W-1:0] deg);
    logic [14:0] scaled;
    logic [29:0] prod;
    logic [WIDTH_W-1:0] quot;
    scaled = 15'(deg) * 15'(DEG_SCALE);
    prod   = 30'(scaled) * 30'(RECIP_NINE);
    quot   = WIDTH_W'(prod >> RECIP_SHIFT);
    return quot + WIDTH_BASE;
  endfunction

endpackage

// ===== rtl/core/ssp_cell.sv =====
// One channel cell: stored width and enable, slot token and line state.
module ssp_cell
  import ssp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  cell_ctrl_t       ctrl,
  input  cell_link_t       link_in,
  output cell_link_t       link_out,
  output logic             line_nxt
);

  logic [WIDTH_W-1:0] width_r, width_nxt;
  logic               en_r, en_nxt;
  logic               token_r, token_nxt;
  logic               line_r;
  logic               wr_hit;

  assign wr_hit = ctrl.wr_valid && (IDX_W'(ctrl.wr_channel) == cell_idx);

  // Take a new target on a set transfer addressed to this cell
  always_comb begin
    width_nxt = wr_hit ? ctrl.wr_width  : width_r;
    en_nxt    = wr_hit ? ctrl.wr_enable : en_r;
  end

  // Advance the token from the neighbor and latch the line at each slot start
  always_comb begin
    token_nxt = ctrl.slot_start ? link_in.tok : token_r;
    line_nxt  = ctrl.slot_start ? (token_r && en_r) : line_r;
  end

  // Pass own token on, and drive own width onto the chain when holding the token
  always_comb begin
    link_out.tok   = token_r;
    link_out.width = token_r ? width_r : link_in.width;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
      en_r    <= 1'b0;
      token_r <= (cell_idx == '0);
      line_r  <= 1'b0;
    end else begin
      width_r <= width_nxt;
      en_r    <= en_nxt;
      token_r <= token_nxt;
      line_r  <= line_nxt;
    end
  end

endmodule

// ===== rtl/core/ssp_timer.sv =====
// Slot and frame timer: slot countdown, frame remainder, period register and idle slot token.
module ssp_timer
  import ssp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tick,
  input  logic               cfg_we,
  input  logic [TICK_W-1:0]  cfg_data,
  input  logic [WIDTH_W-1:0] slot_width,
  input  logic               last_token,
  output logic               slot_start,
  output logic               idle_token
);

  logic [TICK_W-1:0] period_r, period_nxt;
  logic [TICK_W-1:0] slot_left_r, slot_left_nxt;
  logic [TICK_W-1:0] frame_left_r, frame_left_nxt;
  logic              idle_r, idle_nxt;
  logic [TICK_W-1:0] width_ext;
  logic [TICK_W-1:0] idle_len;

  assign slot_start = tick && (slot_left_r == '0);
  assign idle_token = idle_r;
  assign width_ext  = TICK_W'(slot_width);
  assign idle_len   = (frame_left_r == '0) ? TICK_W'(1) : frame_left_r;

  // Hold the period until a configuration write
  assign period_nxt = cfg_we ? cfg_data : period_r;

  // Count down within a slot; on each slot start reload it and update frame remainder and idle token
  always_comb begin
    slot_left_nxt  = slot_left_r;
    frame_left_nxt = frame_left_r;
    idle_nxt       = idle_r;
    if (tick) begin
      if (slot_left_r != '0) begin
        slot_left_nxt = slot_left_r - TICK_W'(1);
      end else if (idle_r) begin
        slot_left_nxt  = idle_len - TICK_W'(1);
        frame_left_nxt = period_r;
        idle_nxt       = 1'b0;
      end else begin
        slot_left_nxt  = (width_ext == '0) ? '0 : width_ext - TICK_W'(1);
        frame_left_nxt = (width_ext > frame_left_r) ? '0 : frame_left_r - width_ext;
        idle_nxt       = last_token;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r     <= FRAME_DEFAULT;
      slot_left_r  <= '0;
      frame_left_r <= FRAME_DEFAULT;
      idle_r       <= 1'b0;
    end else begin
      period_r     <= period_nxt;
      slot_left_r  <= slot_left_nxt;
      frame_left_r <= frame_left_nxt;
      idle_r       <= idle_nxt;
    end
  end

endmodule

// ===== rtl/core/sequential_servo_pulse_generator.sv =====
// Top level of the sequential servo pulse generator: cell chain, timer and output register.
//
//   port group | direction | handshake            | payload
//   in_        | input     | in_valid / in_stall   | in_item_t  (mode, channel, degree, enable)
//   out_       | output    | out_valid / out_stall | out_item_t (servo_lines, frame_start)
//   cfg_       | input     | cfg_we                | frame_period (16 bit)
//
// One item per clock unless the output stalls; a set item writes its cell, a tick item steps
// the timer, and the result appears in the output register on the next cycle.
// The output register alone sets the rate; an item is taken whenever that register is empty
// or being emptied in the same cycle.
// Synchronous active-low reset initializes all cells and the timer, and clears out_valid.
module sequential_servo_pulse_generator
  import ssp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_data
);

  logic               in_xfer;
  logic               tick;
  logic               slot_start;
  logic               idle_token;
  cell_ctrl_t         ctrl;
  cell_link_t         links [CHANNELS+1];
  logic [CHANNELS-1:0] lines_nxt;
  logic [LINES_W-1:0] lines_out;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  // Stall only while a result waits and the far side holds it
  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign tick     = in_xfer && !in_data.mode;

  // Broadcast control to the cells
  always_comb begin
    ctrl.slot_start = slot_start;
    ctrl.wr_valid   = in_xfer && in_data.mode;
    ctrl.wr_channel = in_data.channel;
    ctrl.wr_width   = deg_to_width(in_data.degree);
    ctrl.wr_enable  = in_data.enable;
  end

  // Head of the chain: token from the idle slot, no width
  assign links[0].tok   = idle_token;
  assign links[0].width = '0;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
    ssp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .ctrl     (ctrl),
      .link_in  (links[i]),
      .link_out (links[i+1]),
      .line_nxt (lines_nxt[i])
    );
  end

  ssp_timer u_timer (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (tick),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .slot_width (links[CHANNELS].width),
    .last_token (links[CHANNELS].tok),
    .slot_start (slot_start),
    .idle_token (idle_token)
  );

  // Map cell lines onto the fixed-width line field
  for (genvar j = 0; j < LINES_W; j++) begin : g_line
    if (j < CHANNELS) begin : g_used
      assign lines_out[j] = lines_nxt[j];
    end else begin : g_unused
      assign lines_out[j] = 1'b0;
    end
  end

  // Load a result on each input transfer, drop it once taken
  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (in_xfer) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.servo_lines = lines_out;
      out_data_nxt.frame_start = slot_start && links[1].tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/ssp_checker.sv =====
// Port-level checker for the servo pulse generator, bound to the top level.
module ssp_checker
  import ssp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input out_item_t         out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Stall the input only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // Drive at most one servo line at a time
  a_one_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_data.servo_lines))
    else $error("more than one servo line high");

  // Open each frame with only the first channel's line possible
  a_frame_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_start |->
      (out_data.servo_lines == 6'd0) || (out_data.servo_lines == 6'd1))
    else $error("frame start with a line other than channel zero");

  // Produce a result only for an accepted item
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result without an input transfer");

endmodule

bind sequential_servo_pulse_generator ssp_checker u_ssp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
